>>> src/bca_pkg.sv
`timescale 1ns / 1ps

package bca_pkg;

    // field and register widths
    localparam int SIZE_W      = 16;
    localparam int BYTES_W     = 13;
    localparam int COUNT_REG_W = 7;
    localparam int START_W     = 6;
    localparam int RUN_W       = 6;
    localparam int FREE_W      = 7;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 13;
    localparam int DIV_STEP_W  = $clog2(SIZE_W + 1);

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCKS_IN_USE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_BYTES   = 1'd1;

    localparam logic [COUNT_REG_W-1:0] BLOCKS_IN_USE_RESET = 7'd64;
    localparam logic [BYTES_W-1:0]     BLOCK_BYTES_RESET   = 13'd32;

    // request modes
    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_NO_SPACE     = 2'd1,
        STATUS_OUT_OF_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic               mode;
        logic [SIZE_W-1:0]  byte_size;
        logic [START_W-1:0] start_block;
    } req_word_t;

    typedef struct packed {
        status_t           status;
        logic [RUN_W-1:0]  run_start;
        logic [FREE_W-1:0] free_blocks;
    } rsp_word_t;

    // divider handshake
    typedef struct packed {
        logic               start;
        logic [SIZE_W-1:0]  dividend;
        logic [BYTES_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [SIZE_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> src/bca_stream_if.sv
`timescale 1ns / 1ps

interface bca_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> src/bca_ram.sv
`timescale 1ns / 1ps

module bca_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

>>> src/bca_divider.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle, rounds the quotient up
module bca_divider
    import bca_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic [SIZE_W-1:0]     quo_reg;
    logic [BYTES_W-1:0]    rem_reg;
    logic [BYTES_W-1:0]    dvs_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic                  done_reg;
    logic [BYTES_W:0]      trial;
    logic                  fits;

    assign trial = {rem_reg, quo_reg[SIZE_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (step_reg == DIV_STEP_W'(1));
            if (req.start)
            begin
                step_reg <= DIV_STEP_W'(SIZE_W);
            end
            else if (step_reg != '0)
            begin
                step_reg <= step_reg - DIV_STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            // a zero block size counts as one byte
            dvs_reg <= (req.divisor == '0) ? BYTES_W'(1) : req.divisor;
        end
        else if (step_reg != '0)
        begin
            quo_reg <= {quo_reg[SIZE_W-2:0], fits};
            rem_reg <= fits ? BYTES_W'(trial - {1'b0, dvs_reg}) : trial[BYTES_W-1:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg + SIZE_W'(rem_reg != '0);
endmodule

>>> src/bitmap_contiguous_allocator.sv
`timescale 1ns / 1ps

// first-fit allocator over a one-bit-per-block occupancy map held in a small
// ram. a request word gives a mode, a byte size and, for release, a start
// block; the size is turned into a block count by an iterative divider.
// allocate then walks the map one block per cycle from block 0 until a run
// of free blocks is long enough and writes the run one block per cycle;
// release walks and frees the run one block per cycle. the free count is
// kept incrementally; a write to blocks_in_use starts a recount once the
// allocator is idle. after reset the map is cleared one block per cycle and
// then counted, and req.ready rises only after the count. one request is
// worked on at a time; a finished result word waits in the output register
// while the next request is taken.
module bitmap_contiguous_allocator
    import bca_pkg::*;
#(
    parameter int MAX_BLOCKS = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    bca_stream_if.sink             req,
    bca_stream_if.source           rsp,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);
    localparam int ADDR_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int WIDE_W = SIZE_W + 1;

    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_RECOUNT = 8'b0000_0010,
        S_IDLE    = 8'b0000_0100,
        S_DIVIDE  = 8'b0000_1000,
        S_SCAN    = 8'b0001_0000,
        S_MARK    = 8'b0010_0000,
        S_FREE    = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [COUNT_REG_W-1:0] biu_reg;
    logic [BYTES_W-1:0]     bb_reg;
    logic                   cfg_biu_write;
    logic                   recount_req_reg, recount_req_next;

    // request context
    logic               mode_reg, mode_next;
    logic [START_W-1:0] start_reg, start_next;

    // walk state
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] end_reg, end_next;
    logic [CNT_W-1:0] run_reg, run_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             rd_pend_reg, rd_pend_next;
    logic [CNT_W-1:0] free_reg, free_next;
    status_t          status_reg, status_next;
    logic [RUN_W-1:0] first_reg, first_next;

    // result register
    logic      rsp_valid_reg, rsp_valid_next;
    rsp_word_t rsp_word_reg, rsp_word_next;

    // derived values
    logic [CNT_W-1:0]  limit;
    logic [WIDE_W-1:0] limit_w;
    logic [WIDE_W-1:0] need_w;
    logic [WIDE_W-1:0] start_w;
    logic [WIDE_W-1:0] rel_end_w;
    logic              issue;
    logic              accept;

    // map ram
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [0:0]        ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [0:0]        ram_q;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // blocks managed, saturated at the built capacity
    always_comb
    begin
        if (32'(biu_reg) > 32'(MAX_BLOCKS))
        begin
            limit = CNT_W'(MAX_BLOCKS);
        end
        else
        begin
            limit = CNT_W'(biu_reg);
        end
    end

    assign limit_w   = WIDE_W'(limit);
    assign need_w    = WIDE_W'(div_rsp.quotient);
    assign start_w   = WIDE_W'(start_reg);
    assign rel_end_w = start_w + need_w;
    assign issue     = idx_reg < end_reg;

    assign cfg_biu_write = cfg_we && (cfg_index == REG_BLOCKS_IN_USE);

    // hold off new words while a recount is due
    assign req.ready = (state_reg == S_IDLE) && !recount_req_reg && !cfg_biu_write;
    assign accept    = req.valid && req.ready;

    assign div_req.start    = accept;
    assign div_req.dividend = req.payload.byte_size;
    assign div_req.divisor  = bb_reg;

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_word_reg;

    always_comb
    begin
        state_next       = state_reg;
        recount_req_next = recount_req_reg || cfg_biu_write;
        mode_next        = mode_reg;
        start_next       = start_reg;
        idx_next         = idx_reg;
        end_next         = end_reg;
        run_next         = run_reg;
        rd_idx_next      = rd_idx_reg;
        rd_pend_next     = 1'b0;
        free_next        = free_reg;
        status_next      = status_reg;
        first_next       = first_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        rsp_word_next    = rsp_word_reg;
        ram_we           = 1'b0;
        ram_waddr        = idx_reg[ADDR_W-1:0];
        ram_wdata        = 1'b0;
        ram_re           = 1'b0;
        ram_raddr        = idx_reg[ADDR_W-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we   = 1'b1;
                idx_next = idx_reg + CNT_W'(1);
                if (idx_reg == CNT_W'(MAX_BLOCKS - 1))
                begin
                    state_next       = S_RECOUNT;
                    recount_req_next = cfg_biu_write;
                    idx_next         = '0;
                    end_next         = limit;
                    free_next        = '0;
                end
            end

            S_RECOUNT:
            begin
                ram_re       = issue;
                rd_pend_next = issue;
                rd_idx_next  = idx_reg;
                if (issue)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                if (rd_pend_reg)
                begin
                    free_next = free_reg + CNT_W'(!ram_q[0]);
                end
                if (!issue && !rd_pend_reg)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (recount_req_reg)
                begin
                    state_next       = S_RECOUNT;
                    recount_req_next = cfg_biu_write;
                    idx_next         = '0;
                    end_next         = limit;
                    free_next        = '0;
                end
                else if (accept)
                begin
                    state_next = S_DIVIDE;
                    mode_next  = req.payload.mode;
                    start_next = req.payload.start_block;
                end
            end

            S_DIVIDE:
            begin
                if (div_rsp.done)
                begin
                    status_next = STATUS_OK;
                    first_next  = '0;
                    if (mode_reg == MODE_ALLOC)
                    begin
                        if (need_w == '0 || need_w > limit_w)
                        begin
                            status_next = STATUS_NO_SPACE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            idx_next   = '0;
                            end_next   = limit;
                            run_next   = '0;
                            state_next = S_SCAN;
                        end
                    end
                    else if (need_w == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else if (start_w >= limit_w)
                    begin
                        // whole run past the managed blocks
                        status_next = STATUS_OUT_OF_RANGE;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        idx_next = CNT_W'(start_reg);
                        if (rel_end_w > limit_w)
                        begin
                            end_next    = limit;
                            status_next = STATUS_OUT_OF_RANGE;
                        end
                        else
                        begin
                            end_next = CNT_W'(rel_end_w);
                        end
                        state_next = S_FREE;
                    end
                end
            end

            S_SCAN:
            begin
                ram_re       = issue;
                rd_pend_next = issue;
                rd_idx_next  = idx_reg;
                if (issue)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                if (rd_pend_reg)
                begin
                    if (ram_q[0])
                    begin
                        run_next = '0;
                    end
                    else
                    begin
                        run_next = run_reg + CNT_W'(1);
                    end
                end
                if (rd_pend_reg && !ram_q[0]
                    && (WIDE_W'(run_reg) + WIDE_W'(1) == need_w))
                begin
                    // run found, mark it from its first block
                    idx_next     = rd_idx_reg + CNT_W'(1) - CNT_W'(div_rsp.quotient);
                    end_next     = rd_idx_reg + CNT_W'(1);
                    first_next   = RUN_W'(rd_idx_reg + CNT_W'(1)
                                          - CNT_W'(div_rsp.quotient));
                    free_next    = free_reg - CNT_W'(div_rsp.quotient);
                    rd_pend_next = 1'b0;
                    state_next   = S_MARK;
                end
                else if (!issue && !rd_pend_reg)
                begin
                    status_next = STATUS_NO_SPACE;
                    state_next  = S_DONE;
                end
            end

            S_MARK:
            begin
                ram_we    = 1'b1;
                ram_wdata = 1'b1;
                idx_next  = idx_reg + CNT_W'(1);
                if (idx_reg + CNT_W'(1) == end_reg)
                begin
                    state_next = S_DONE;
                end
            end

            S_FREE:
            begin
                ram_re       = issue;
                rd_pend_next = issue;
                rd_idx_next  = idx_reg;
                if (issue)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                // clear the block read last cycle, count it if it was taken
                if (rd_pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = rd_idx_reg[ADDR_W-1:0];
                    free_next = free_reg + CNT_W'(ram_q[0]);
                end
                if (!issue && !rd_pend_reg)
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_word_next.status      = status_reg;
                    rsp_word_next.run_start   = first_reg;
                    rsp_word_next.free_blocks = FREE_W'(free_reg);
                    state_next                = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            biu_reg         <= BLOCKS_IN_USE_RESET;
            bb_reg          <= BLOCK_BYTES_RESET;
            recount_req_reg <= 1'b0;
            idx_reg         <= '0;
            end_reg         <= '0;
            rd_pend_reg     <= 1'b0;
            free_reg        <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            recount_req_reg <= recount_req_next;
            idx_reg         <= idx_next;
            end_reg         <= end_next;
            rd_pend_reg     <= rd_pend_next;
            free_reg        <= free_next;
            rsp_valid_reg   <= rsp_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BLOCKS_IN_USE: biu_reg <= cfg_data[COUNT_REG_W-1:0];
                    REG_BLOCK_BYTES:   bb_reg  <= cfg_data[BYTES_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        start_reg    <= start_next;
        run_reg      <= run_next;
        rd_idx_reg   <= rd_idx_next;
        status_reg   <= status_next;
        first_reg    <= first_next;
        rsp_word_reg <= rsp_word_next;
    end

    bca_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    bca_ram #(
        .WIDTH (1),
        .DEPTH (MAX_BLOCKS)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );
endmodule

>>> src/bca_checker.sv
`timescale 1ns / 1ps

module bca_checker
    import bca_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input rsp_word_t rsp_word
);
    // result word stays offered until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result word dropped before taken");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_word))
        else $error("stalled result word changed");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    a_no_space_start: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_word.status == STATUS_NO_SPACE) |-> rsp_word.run_start == '0)
        else $error("failed allocation reports a start block");
endmodule

bind bitmap_contiguous_allocator bca_checker u_bca_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_word  (rsp.payload)
);
